FILE: rtl/edf_pkg.sv
package edf_pkg;

  // Table geometry
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int DATA_W      = 32;
  localparam int STACK_W     = 16;
  localparam int PORT_SLOT_W = 4;

  // Configuration reset values
  localparam logic [DATA_W-1:0]  DEFAULT_DEADLINE_RST = 32'd5;
  localparam logic [STACK_W-1:0] MIN_STACK_RST        = 16'd512;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [2:0] {
    OP_CREATE       = 3'd0,
    OP_EXIT         = 3'd1,
    OP_YIELD        = 3'd2,
    OP_SET_DEADLINE = 3'd3,
    OP_SWITCH       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DORMANT = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_st_t;

  typedef enum logic {
    CFG_DEFAULT_DEADLINE = 1'b0,
    CFG_MIN_STACK        = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CMP_RD,
    S_CMP,
    S_YIELD_LD,
    S_SCAN_INIT,
    S_SCAN,
    S_SCAN_END,
    S_DONE
  } seq_state_t;

  // Control of the shared compare / minimum unit
  typedef struct packed {
    logic      init;      // start a new minimum search
    logic      step;      // fold one candidate into the search
    logic      elig;      // candidate slot may be chosen
    logic      use_best;  // compare against running minimum instead of b operand
    slot_idx_t idx;       // slot index of the candidate
    slot_idx_t dflt;      // pick kept when no slot qualifies
  } cmp_ctl_t;

endpackage

FILE: rtl/edf_ram.sv
module edf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/edf_minunit.sv
module edf_minunit import edf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmp_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              lt_o,
  output slot_idx_t         pick_o
);

  logic              found_r, found_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  slot_idx_t         pick_r, pick_nxt;
  logic [DATA_W-1:0] rhs;
  logic              take;

  // Single unsigned comparator, shared by the compare step and the minimum scan of the sequencer
  assign rhs  = ctl_i.use_best ? best_r : b_i;
  assign lt_o = a_i < rhs;

  // Strict less-than keeps the lowest index on ties
  assign take = ctl_i.step && ctl_i.elig && (!found_r || lt_o);

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    if (ctl_i.init) begin
      found_nxt = 1'b0;
      pick_nxt  = ctl_i.dflt;
    end else if (take) begin
      found_nxt = 1'b1;
      best_nxt  = a_i;
      pick_nxt  = ctl_i.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    pick_r <= pick_nxt;
  end

  assign pick_o = pick_r;

endmodule

FILE: rtl/edf_task_scheduler.sv
// Channel  Handshake              Payload
// -------  ---------------------  ---------------------------------------------------
// in       start / busy           in_operation, in_task_slot, in_deadline_value,
//                                 in_stack_bytes
// out      out_valid (strobe)     out_status, out_created_slot, out_switch_request,
//                                 out_selected_slot, out_running_slot
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is taken when start is high and busy is low; its result strobes out_valid
// for one cycle when the sequencer reaches its done state, soonest for a switch or an
// error, latest for a set deadline with a reschedule; busy drops the cycle after the strobe.
// A reschedule walks all SLOTS entries of the time-left memory through its single read
// port into one comparator.
// Reset is synchronous, active low; no clearing pass, unwritten entries read as zero.
// The receiver cannot stall; cfg_ready is always high.
module edf_task_scheduler import edf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_operation,
  input  logic [3:0]                in_task_slot,
  input  logic signed [DATA_W-1:0]  in_deadline_value,
  input  logic [STACK_W-1:0]        in_stack_bytes,
  output logic                      out_valid,
  output logic                      out_status,
  output logic [PORT_SLOT_W-1:0]    out_created_slot,
  output logic                      out_switch_request,
  output logic [PORT_SLOT_W-1:0]    out_selected_slot,
  output logic [PORT_SLOT_W-1:0]    out_running_slot,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [DATA_W-1:0]         cfg_data
);

  // Sequencer and table state
  seq_state_t          state_r, state_nxt;
  logic [SLOTS-1:0]    live_r, live_nxt;
  slot_st_t            stat_r [SLOTS];
  slot_st_t            stat_nxt [SLOTS];
  slot_idx_t           current_r, current_nxt;
  slot_idx_t           chosen_r, chosen_nxt;
  logic [CNT_W-1:0]    live_cnt_r, live_cnt_nxt;
  logic [CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [SLOTS-1:0]    tl_vld_r, tl_vld_nxt;
  logic [SLOTS-1:0]    dl_vld_r, dl_vld_nxt;
  logic                tl_vq_r, dl_vq_r;

  // Configuration
  logic [DATA_W-1:0]   def_dl_r, def_dl_nxt;
  logic [STACK_W-1:0]  min_stack_r, min_stack_nxt;

  // Latched item and result
  logic [2:0]          op_r, op_nxt;
  logic [3:0]          tslot_r, tslot_nxt;
  logic [DATA_W-1:0]   draw_r, draw_nxt;
  logic [STACK_W-1:0]  stack_r, stack_nxt;
  logic                err_r, err_nxt;
  logic                sw_r, sw_nxt;
  slot_idx_t           created_r, created_nxt;

  // Memory ports
  logic                tl_we, dl_we;
  slot_idx_t           tl_waddr, dl_waddr;
  logic [DATA_W-1:0]   tl_wdata, dl_wdata;
  slot_idx_t           tl_raddr;
  logic [DATA_W-1:0]   tl_rdata, dl_rdata;
  logic [DATA_W-1:0]   tl_q, dl_q;

  // Compare unit
  cmp_ctl_t            cmp_ctl;
  logic [DATA_W-1:0]   cmp_a, cmp_b;
  logic                cmp_lt;
  slot_idx_t           cmp_pick;

  // Decode helpers
  logic                accept;
  logic                free_found;
  slot_idx_t           free_idx;
  slot_idx_t           tidx;
  logic [CNT_W-1:0]    scan_prev;
  slot_idx_t           scan_idx;
  logic                create_ok, exit_ok, setdl_ok;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  assign tidx      = SLOT_W'(tslot_r);
  assign scan_prev = scan_cnt_r - CNT_W'(1);
  assign scan_idx  = scan_prev[SLOT_W-1:0];

  // Unwritten entries read as zero
  assign tl_q = tl_vq_r ? tl_rdata : '0;
  assign dl_q = dl_vq_r ? dl_rdata : '0;

  // First free or dormant slot from 1 upward
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (!live_r[i] || stat_r[i] == ST_DORMANT) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign create_ok = (live_cnt_r < CNT_W'(SLOTS)) && (stack_r >= min_stack_r) && free_found;
  assign exit_ok   = (current_r != '0) && live_r[current_r];
  assign setdl_ok  = (draw_r != '0) && !draw_r[DATA_W-1] &&
                     (32'(tslot_r) < 32'(SLOTS)) && (tidx != current_r) &&
                     (stat_r[tidx] == ST_READY);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_CREATE:       state_nxt = create_ok ? S_CMP_RD : S_DONE;
          OP_EXIT:         state_nxt = exit_ok ? S_SCAN_INIT : S_DONE;
          OP_YIELD:        state_nxt = S_YIELD_LD;
          OP_SET_DEADLINE: state_nxt = setdl_ok ? S_CMP_RD : S_DONE;
          default:         state_nxt = S_DONE;
        endcase
      end
      S_CMP_RD:    state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = (op_r == OP_SET_DEADLINE && cmp_lt) ? S_SCAN_INIT : S_DONE;
      end
      S_YIELD_LD:  state_nxt = S_SCAN_INIT;
      S_SCAN_INIT: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_cnt_r == CNT_W'(SLOTS)) state_nxt = S_SCAN_END;
      end
      S_SCAN_END:  state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and table updates
  always_comb begin
    live_nxt     = live_r;
    stat_nxt     = stat_r;
    current_nxt  = current_r;
    chosen_nxt   = chosen_r;
    live_cnt_nxt = live_cnt_r;
    scan_cnt_nxt = scan_cnt_r;
    tl_vld_nxt   = tl_vld_r;
    dl_vld_nxt   = dl_vld_r;
    op_nxt       = op_r;
    tslot_nxt    = tslot_r;
    draw_nxt     = draw_r;
    stack_nxt    = stack_r;
    err_nxt      = err_r;
    sw_nxt       = sw_r;
    created_nxt  = created_r;
    tl_we        = 1'b0;
    tl_waddr     = current_r;
    tl_wdata     = def_dl_r;
    dl_we        = 1'b0;
    dl_waddr     = current_r;
    dl_wdata     = def_dl_r;
    tl_raddr     = current_r;
    cmp_ctl      = '0;
    cmp_ctl.dflt = chosen_r;
    cmp_ctl.idx  = scan_idx;
    cmp_a        = (op_r == OP_CREATE) ? def_dl_r : draw_r;
    cmp_b        = (op_r == OP_CREATE) ? tl_q : dl_q;

    unique case (state_r)
      S_IDLE: begin
        // Latch the item
        if (accept) begin
          op_nxt      = in_operation;
          tslot_nxt   = in_task_slot;
          draw_nxt    = $unsigned(in_deadline_value);
          stack_nxt   = in_stack_bytes;
          err_nxt     = 1'b0;
          sw_nxt      = 1'b0;
          created_nxt = '0;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_CREATE: begin
            if (create_ok) begin
              live_nxt[free_idx]   = 1'b1;
              stat_nxt[free_idx]   = ST_READY;
              tl_we                = 1'b1;
              tl_waddr             = free_idx;
              tl_wdata             = def_dl_r;
              dl_we                = 1'b1;
              dl_waddr             = free_idx;
              dl_wdata             = def_dl_r;
              tl_vld_nxt[free_idx] = 1'b1;
              dl_vld_nxt[free_idx] = 1'b1;
              live_cnt_nxt         = live_cnt_r + CNT_W'(1);
              created_nxt          = free_idx;
            end else begin
              err_nxt = 1'b1;
            end
          end
          OP_EXIT: begin
            if (exit_ok) begin
              stat_nxt[current_r] = ST_DORMANT;
              live_nxt[current_r] = 1'b0;
              if (live_cnt_r != '0) live_cnt_nxt = live_cnt_r - CNT_W'(1);
              sw_nxt = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          OP_YIELD: begin
            sw_nxt = 1'b1;
          end
          OP_SET_DEADLINE: begin
            if (setdl_ok) begin
              tl_we            = 1'b1;
              tl_waddr         = tidx;
              tl_wdata         = draw_r;
              dl_we            = 1'b1;
              dl_waddr         = tidx;
              dl_wdata         = draw_r;
              tl_vld_nxt[tidx] = 1'b1;
              dl_vld_nxt[tidx] = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          OP_SWITCH: begin
            // Running slot goes back to ready unless it exited
            if (stat_r[current_r] != ST_DORMANT) stat_nxt[current_r] = ST_READY;
            stat_nxt[chosen_r] = ST_RUNNING;
            current_nxt        = chosen_r;
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
      S_CMP_RD: begin
        // Read of the running slot is in flight
      end
      S_CMP: begin
        sw_nxt = cmp_lt;
      end
      S_YIELD_LD: begin
        // Reload time left from deadline
        tl_we                 = 1'b1;
        tl_waddr              = current_r;
        tl_wdata              = dl_q;
        tl_vld_nxt[current_r] = 1'b1;
      end
      S_SCAN_INIT: begin
        cmp_ctl.init = 1'b1;
        tl_raddr     = '0;
        scan_cnt_nxt = CNT_W'(1);
      end
      S_SCAN: begin
        // Fold the previous slot, fetch the next one
        cmp_ctl.step     = 1'b1;
        cmp_ctl.use_best = 1'b1;
        cmp_ctl.elig     = live_r[scan_idx] &&
                           (stat_r[scan_idx] == ST_READY || stat_r[scan_idx] == ST_RUNNING);
        cmp_a            = tl_q;
        tl_raddr         = scan_cnt_r[SLOT_W-1:0];
        if (scan_cnt_r != CNT_W'(SLOTS)) scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
      end
      S_SCAN_END: begin
        chosen_nxt = cmp_pick;
      end
      S_DONE: begin
        // Result strobe
      end
      default: begin
      end
    endcase
  end

  // Configuration decode
  always_comb begin
    def_dl_nxt    = def_dl_r;
    min_stack_nxt = min_stack_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEFAULT_DEADLINE: def_dl_nxt    = cfg_data;
        CFG_MIN_STACK:        min_stack_nxt = cfg_data[STACK_W-1:0];
        default:              def_dl_nxt    = def_dl_r;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      current_r   <= '0;
      chosen_r    <= '0;
      live_cnt_r  <= CNT_W'(1);
      scan_cnt_r  <= '0;
      tl_vld_r    <= '0;
      dl_vld_r    <= '0;
      def_dl_r    <= DEFAULT_DEADLINE_RST;
      min_stack_r <= MIN_STACK_RST;
      for (int i = 0; i < SLOTS; i++) begin
        stat_r[i] <= ST_DORMANT;
      end
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      current_r   <= current_nxt;
      chosen_r    <= chosen_nxt;
      live_cnt_r  <= live_cnt_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      tl_vld_r    <= tl_vld_nxt;
      dl_vld_r    <= dl_vld_nxt;
      def_dl_r    <= def_dl_nxt;
      min_stack_r <= min_stack_nxt;
      stat_r      <= stat_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    tslot_r   <= tslot_nxt;
    draw_r    <= draw_nxt;
    stack_r   <= stack_nxt;
    err_r     <= err_nxt;
    sw_r      <= sw_nxt;
    created_r <= created_nxt;
    tl_vq_r   <= tl_vld_r[tl_raddr];
    dl_vq_r   <= dl_vld_r[current_r];
  end

  // Time-left and deadline memories
  edf_ram #(
    .DEPTH (SLOTS),
    .WIDTH (DATA_W)
  ) u_tl_ram (
    .clk   (clk),
    .we    (tl_we),
    .waddr (tl_waddr),
    .wdata (tl_wdata),
    .raddr (tl_raddr),
    .rdata (tl_rdata)
  );

  edf_ram #(
    .DEPTH (SLOTS),
    .WIDTH (DATA_W)
  ) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (current_r),
    .rdata (dl_rdata)
  );

  // Shared compare unit
  edf_minunit u_minunit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (cmp_ctl),
    .a_i    (cmp_a),
    .b_i    (cmp_b),
    .lt_o   (cmp_lt),
    .pick_o (cmp_pick)
  );

  // Result ports
  assign out_valid          = state_r == S_DONE;
  assign out_status         = err_r;
  assign out_created_slot   = PORT_SLOT_W'(created_r);
  assign out_switch_request = sw_r;
  assign out_selected_slot  = PORT_SLOT_W'(chosen_r);
  assign out_running_slot   = PORT_SLOT_W'(current_r);

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy after result strobe");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_chosen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN_END) |=> $stable(chosen_r))
    else $error("selection changed outside reschedule");

  a_created_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status && op_r == OP_CREATE) |-> live_r[created_r])
    else $error("created slot not live");
`endif

endmodule
